### sv/rgbhsl_pkg.sv
// Package for the RGB to HSL converter: payload structs, widths and constants.
// Used by rgbhsl_div and rgb_to_hsl_converter_top; depends on nothing.
package rgbhsl_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam int FULL_SCALE   = (1 << CHANNEL_BITS) - 1;

	// Divider widths: numerator, denominator, quotient bits
	localparam int NUM_W = 25;
	localparam int DEN_W = 11;
	localparam int QUO_W = 16;

	// Scale factors (doubled for round half up) and limits
	localparam int SCALE2    = 20000;
	localparam int HUE_STEP2 = 12000;
	localparam int HUE_FULL  = 36000;
	localparam int WHITE_SUM = 485;
	localparam int BLACK_SUM = 25;

	// Lightness by reciprocal: floor((1000*S + 25) / 51) == (S*MUL + ADD) >> SHIFT
	localparam logic [31:0] LIGHT_MUL   = 32'd2631721000;
	localparam logic [31:0] LIGHT_ADD   = 32'd65793025;
	localparam int          LIGHT_SHIFT = 27;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [15:0] hue;
		logic [13:0] saturation;
		logic [13:0] adjusted_saturation;
		logic [13:0] lightness;
	} result_t;

endpackage

### sv/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, QUO_W stages.
// Depends on rgbhsl_pkg for its widths; the quotient must fit in QUO_W bits.
module rgbhsl_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rgbhsl_pkg::NUM_W-1:0]  num,
	input  logic [rgbhsl_pkg::DEN_W-1:0]  den,
	output logic [rgbhsl_pkg::QUO_W-1:0]  quo
);

	localparam int QW = rgbhsl_pkg::QUO_W;
	localparam int DW = rgbhsl_pkg::DEN_W;
	localparam int NW = rgbhsl_pkg::NUM_W;

	logic [DW-1:0] rem_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];

	// Entry: upper numerator bits seed the remainder
	assign rem_s[0] = DW'(num[NW-1:QW]);
	assign den_s[0] = den;
	assign low_s[0] = num[QW-1:0];
	assign quo_s[0] = '0;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          ge;
		logic [DW-1:0] rem_nx;

		// One subtract and compare per stage
		always_comb begin
			trial  = {rem_s[k], low_s[k][QW-1]};
			ge     = (trial >= {1'b0, den_s[k]});
			rem_nx = ge ? DW'(trial - {1'b0, den_s[k]}) : DW'(trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				den_s[k+1] <= den_s[k];
				low_s[k+1] <= {low_s[k][QW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QW];

endmodule

### sv/rgb_to_hsl_converter_top.sv
// RGB to HSL converter: top level with input, setup and output stages.
// Depends on rgbhsl_pkg and rgbhsl_div.
//
// Takes one 8-bit RGB pixel per clock and returns hue (0.01 deg), saturation,
// adjusted saturation and lightness (0.01 %), each rounded half up. A word
// is taken every cycle while the output register is empty or being drained;
// the pipe has three setup stages, 16 divider stages (one quotient bit each)
// and the output register. Lightness is a reciprocal multiply in the third
// setup stage and waits alongside the dividers. The whole pipe holds while
// the output word waits. The user must write chroma epsilon through the cfg
// port only when idle; the block itself does not enforce it.
module rgb_to_hsl_converter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  rgbhsl_pkg::pixel_t  pixel,
	output logic                result_valid,
	input  logic                result_ready,
	output rgbhsl_pkg::result_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	localparam int QW = rgbhsl_pkg::QUO_W;
	localparam int DW = rgbhsl_pkg::DEN_W;
	localparam int NW = rgbhsl_pkg::NUM_W;

	logic en;
	logic [7:0] eps_q;

	// Config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// Whole pipe advances unless the output word is stuck
	assign en          = !result_valid || result_ready;
	assign pixel_ready = en;

	// Stage 1: capture pixel
	logic vld_s1;
	logic [7:0] r_s1, g_s1, b_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pixel_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= pixel.red;
			g_s1 <= pixel.green;
			b_s1 <= pixel.blue;
		end
	end

	// Stage 2: max, min, sum, chroma, hue difference
	logic [7:0] mx_c, mn_c, d_c;
	logic [8:0] sum_c;
	logic signed [11:0] t_c;
	always_comb begin
		mx_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		mn_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;
		sum_c = {1'b0, mx_c} + {1'b0, mn_c};
		d_c   = mx_c - mn_c;
		priority if (r_s1 == mx_c) begin
			t_c = $signed({4'b0, g_s1}) - $signed({4'b0, b_s1});
		end else if (g_s1 == mx_c) begin
			t_c = $signed({3'b0, d_c, 1'b0}) + $signed({4'b0, b_s1})
				- $signed({4'b0, r_s1});
		end else begin
			t_c = $signed({2'b0, d_c, 2'b0}) + $signed({4'b0, r_s1})
				- $signed({4'b0, g_s1});
		end
		if (t_c < 0) t_c = t_c + $signed(12'(6 * d_c));
	end

	logic vld_s2;
	logic [7:0] mx_s2, d_s2;
	logic [8:0] sum_s2;
	logic [10:0] t_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2  <= mx_c;
			d_s2   <= d_c;
			sum_s2 <= sum_c;
			t_s2   <= t_c[10:0];
		end
	end

	// Stage 3: numerators and denominators for round-half-up ratios, gray flag and lightness
	logic [8:0] sden_c, aden_c;
	logic near_c;
	logic [40:0] lprod_c;
	always_comb begin
		sden_c = (sum_s2 <= 9'(rgbhsl_pkg::FULL_SCALE)) ? sum_s2
			: 9'(2 * rgbhsl_pkg::FULL_SCALE) - sum_s2;
		near_c = (d_s2 < eps_q);
		aden_c = sden_c;
		if (near_c && sum_s2 >= 9'(rgbhsl_pkg::WHITE_SUM)) begin
			aden_c = {1'b0, mx_s2};
		end else if (near_c && sum_s2 <= 9'(rgbhsl_pkg::BLACK_SUM)) begin
			aden_c = 9'(rgbhsl_pkg::FULL_SCALE);
		end
		// lightness = 10000*S/510 rounded, via constant reciprocal
		lprod_c = 41'(sum_s2) * 41'(rgbhsl_pkg::LIGHT_MUL)
			+ 41'(rgbhsl_pkg::LIGHT_ADD);
	end

	logic vld_s3, gray_s3;
	logic [13:0] light_s3;
	logic [NW-1:0] hnum_s3, snum_s3, anum_s3;
	logic [DW-1:0] hden_s3, sden_s3, aden_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gray_s3  <= (d_s2 == '0);
			light_s3 <= lprod_c[rgbhsl_pkg::LIGHT_SHIFT +: 14];
			hnum_s3  <= NW'(t_s2 * 14'(rgbhsl_pkg::HUE_STEP2)) + NW'(d_s2);
			hden_s3  <= DW'({d_s2, 1'b0});
			snum_s3  <= NW'(d_s2 * 15'(rgbhsl_pkg::SCALE2)) + NW'(sden_c);
			sden_s3  <= DW'({sden_c, 1'b0});
			anum_s3  <= NW'(d_s2 * 15'(rgbhsl_pkg::SCALE2)) + NW'(aden_c);
			aden_s3  <= DW'({aden_c, 1'b0});
		end
	end

	// Dividers
	logic [QW-1:0] hq, sq, aq;
	rgbhsl_div u_hdiv (.clk, .en, .num(hnum_s3), .den(hden_s3), .quo(hq));
	rgbhsl_div u_sdiv (.clk, .en, .num(snum_s3), .den(sden_s3), .quo(sq));
	rgbhsl_div u_adiv (.clk, .en, .num(anum_s3), .den(aden_s3), .quo(aq));

	// Valid, gray and lightness ride alongside the dividers
	logic [QW-1:0] vld_line_s, gray_line_s;
	logic [13:0]   light_line_s [QW];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_line_s <= '0;
		end else if (en) begin
			vld_line_s <= {vld_line_s[QW-2:0], vld_s3};
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gray_line_s     <= {gray_line_s[QW-2:0], gray_s3};
			light_line_s[0] <= light_s3;
			for (int k = 1; k < QW; k++) begin
				light_line_s[k] <= light_line_s[k-1];
			end
		end
	end

	// Output register: gray forcing and hue wrap
	logic gray_c;
	assign gray_c = gray_line_s[QW-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= vld_line_s[QW-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			result.hue <= (gray_c || hq >= QW'(rgbhsl_pkg::HUE_FULL)) ? '0 : hq;
			result.saturation          <= gray_c ? '0 : sq[13:0];
			result.adjusted_saturation <= gray_c ? '0 : aq[13:0];
			result.lightness           <= light_line_s[QW-1];
		end
	end

`ifndef SYNTHESIS
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.hue < 16'd36000 && result.saturation <= 14'd10000
			&& result.lightness <= 14'd10000))
		else $error("result out of range");
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturation == '0) |->
			(result.hue == '0 && result.adjusted_saturation == '0))
		else $error("gray word with nonzero hue or saturation");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_ready == (!result_valid || result_ready))
		else $error("input ready does not follow output stall");
`endif

endmodule

### tb/rgbhsl_checker.sv
// Checker for the RGB to HSL converter: watches the pixel, cfg and result channels,
// predicts each result word and compares it. Depends on rgbhsl_pkg.
`timescale 1ns / 1ps

module rgbhsl_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	input  logic                pixel_ready,
	input  rgbhsl_pkg::pixel_t  pixel,
	input  logic                result_valid,
	input  logic                result_ready,
	input  rgbhsl_pkg::result_t result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	output int                  errors,
	output int                  pending
);

	logic [7:0]          epsilon;
	rgbhsl_pkg::result_t hsl_queue[$];

	// round half up: floor((2n + d) / (2d))
	function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
		return (2 * n + d) / (2 * d);
	endfunction

	function automatic rgbhsl_pkg::result_t hsl_of(rgbhsl_pkg::pixel_t p, logic [7:0] eps);
		rgbhsl_pkg::result_t res;
		longint unsigned     r, g, b, mx, mn, s, d, h;
		longint              t;
		r = p.red; g = p.green; b = p.blue;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		s = mx + mn;
		d = mx - mn;
		res = '0;
		res.lightness = 14'(rdiv(s * 10000, 2 * rgbhsl_pkg::FULL_SCALE));
		if (d != 0) begin
			if (s <= rgbhsl_pkg::FULL_SCALE)
				res.saturation = 14'(rdiv(d * 10000, s));
			else
				res.saturation = 14'(rdiv(d * 10000, 2 * rgbhsl_pkg::FULL_SCALE - s));
			res.adjusted_saturation = res.saturation;
			// small chroma near white or black
			if (d < eps) begin
				if (10 * s > 19 * rgbhsl_pkg::FULL_SCALE)
					res.adjusted_saturation = 14'(rdiv(d * 10000, mx));
				else if (10 * s < rgbhsl_pkg::FULL_SCALE)
					res.adjusted_saturation =
						14'(rdiv(d * 10000, rgbhsl_pkg::FULL_SCALE));
			end
			if (r == mx)
				t = longint'(g) - longint'(b);
			else if (g == mx)
				t = 2 * longint'(d) + longint'(b) - longint'(r);
			else
				t = 4 * longint'(d) + longint'(r) - longint'(g);
			if (t < 0)
				t += 6 * longint'(d);
			h = rdiv(longint'(t) * 6000, d);
			if (h >= rgbhsl_pkg::HUE_FULL)
				h = 0;
			res.hue = 16'(h);
		end
		return res;
	endfunction

	assign pending = hsl_queue.size();

	// track config, predict on accepted pixels, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		rgbhsl_pkg::result_t want;
		if (!arst_n) begin
			epsilon <= '0;
			errors  <= 0;
			hsl_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				epsilon <= cfg_data;
			if (pixel_valid && pixel_ready)
				hsl_queue.push_back(hsl_of(pixel, epsilon));
			if (result_valid && result_ready) begin
				if (hsl_queue.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, result);
					errors <= errors + 1;
				end else begin
					want = hsl_queue.pop_front();
					if (want.hue != result.hue ||
					    want.saturation != result.saturation ||
					    want.adjusted_saturation != result.adjusted_saturation ||
					    want.lightness != result.lightness) begin
						$display({"%0t: mismatch expected h=%0d s=%0d a=%0d l=%0d",
							" got h=%0d s=%0d a=%0d l=%0d"},
							$time, want.hue, want.saturation, want.adjusted_saturation,
							want.lightness, result.hue, result.saturation,
							result.adjusted_saturation, result.lightness);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### tb/rgb_to_hsl_converter_top_tb.sv
// Testbench top for rgb_to_hsl_converter_top: makes pixel and cfg stimulus, random stalls,
// and gives the verdict. Depends on the converter top, rgbhsl_pkg and rgbhsl_checker.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_top_tb;

	localparam int LATENCY   = 20;
	localparam int MAX_CYCLE = 400000;

	logic                clk;
	logic                arst_n;
	logic                pixel_valid;
	logic                pixel_ready;
	rgbhsl_pkg::pixel_t  pixel;
	logic                result_valid;
	logic                result_ready;
	rgbhsl_pkg::result_t result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;
	int                  errors;
	int                  pending;
	int                  cycle;
	int                  send_idle;
	int                  recv_idle;

	rgb_to_hsl_converter_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	rgbhsl_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// watchdog
	initial cycle = 0;
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= MAX_CYCLE) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_idle);
	end

	// send one pixel word, with random idle cycles before it; valid stays up
	// after acceptance until the next idle cycle or the caller drops it
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= '{red: r, green: g, blue: b};
		@(posedge clk);
		while (!pixel_ready)
			@(posedge clk);
	endtask

	task automatic write_epsilon(input logic [7:0] value);
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// near-white or near-black pixel with small chroma
	task automatic send_near_extreme();
		logic [7:0] base, spread;
		logic [7:0] c[3];
		base   = $urandom_range(1) ? 8'($urandom_range(255, 235)) : 8'($urandom_range(13));
		spread = 8'($urandom_range(20));
		for (int k = 0; k < 3; k++)
			c[k] = (base > 128) ? base - 8'($urandom_range(spread) % (base + 1))
			                    : base + 8'($urandom_range(spread));
		send_pixel(c[0], c[1], c[2]);
	endtask

	task automatic random_phase(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(3) == 0)
				send_near_extreme();
			else
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [7:0] eps_set[4];
		eps_set = '{8'd0, 8'd255, 8'd30, 8'd1};
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		pixel       = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		send_idle   = 12;
		recv_idle   = 54;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, gray, each hue sector, wrap, near white/black
		write_epsilon(8'd255);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd250, 8'd245, 8'd240);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd12, 8'd0, 8'd13);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'hAA, 8'h55, 8'hAA);
		send_pixel(8'h55, 8'hAA, 8'h55);

		// random phases across epsilon settings and stall profiles
		for (int ph = 0; ph < 12; ph++) begin
			write_epsilon(eps_set[ph % 4]);
			if (ph == 4) begin
				send_idle = 54;
				recv_idle = 12;
			end else if (ph == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_phase(167);
		end

		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
